// File: hw/rtl/height_and_hex_color_token_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Token parser assertion macros
// Concurrent assertion wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_AND_HEX_COLOR_TOKEN_PARSER_CORE_MACROS_SVH
`define HEIGHT_AND_HEX_COLOR_TOKEN_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define HHCP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("token parser assertion failed");
`define HHCP_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("token parser assertion failed");
`else
`define HHCP_ASSERT(lbl, clk, rst, prop)
`define HHCP_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// File: hw/rtl/hhcp_pkg.sv
// ----------------------------------------------------------------------------
// Token parser package
// Shared widths, character codes, error codes, item types and helpers.
// ----------------------------------------------------------------------------
package hhcp_pkg;

   localparam int CH_W      = 8;
   localparam int POS_W     = 10;
   localparam int HEIGHT_W  = 32;
   localparam int COLOR_W   = 8;
   localparam int GRID_SIZE = 1024;
   localparam int REM_W     = 27;

   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_X     = 8'h78;
   localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;
   localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UC_F  = 8'h46;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_DIGIT     = 3'd1,
      ERR_ZERO_X    = 3'd2,
      ERR_HEX_COUNT = 3'd3,
      ERR_OVERFLOW  = 3'd4
   } err_type;

   typedef struct packed {
      logic [CH_W-1:0]  ch;
      logic [POS_W-1:0] grid_x;
      logic [POS_W-1:0] grid_y;
   } req_item_type;

   typedef struct packed {
      logic [POS_W-1:0]           pos_x;
      logic [POS_W-1:0]           pos_y;
      logic signed [HEIGHT_W-1:0] height;
      logic [COLOR_W-1:0]         red;
      logic [COLOR_W-1:0]         green;
      logic [COLOR_W-1:0]         blue;
      logic                       has_color;
      err_type                    error_code;
   } rsp_item_type;

   function automatic logic is_digit(input logic [CH_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [CH_W-1:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (is_digit(c)) begin
         r = {1'b1, c[3:0]};
      end else if (((c >= CH_LC_A) && (c <= CH_LC_F)) ||
                   ((c >= CH_UC_A) && (c <= CH_UC_F))) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   // Position modulo grid size by restoring subtraction
   function automatic logic [POS_W-1:0] pos_reduce(input logic [POS_W-1:0] v);
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] sub;
      rem = REM_W'(v);
      for (int k = POS_W - 1; k >= 0; k--) begin
         sub = REM_W'(GRID_SIZE) << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[POS_W-1:0];
   endfunction

endpackage

// File: hw/rtl/hhcp_if.sv
// ----------------------------------------------------------------------------
// Token parser channel interfaces
// Valid/ready channels for input bytes and finished tokens.
// ----------------------------------------------------------------------------
interface hhcp_req_if;
   logic                            valid;
   logic                            ready;
   logic [hhcp_pkg::CH_W-1:0]       ch;
   logic [hhcp_pkg::POS_W-1:0]      grid_x;
   logic [hhcp_pkg::POS_W-1:0]      grid_y;

   modport source (output valid, ch, grid_x, grid_y, input ready);
   modport sink   (input valid, ch, grid_x, grid_y, output ready);
endinterface

interface hhcp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [hhcp_pkg::POS_W-1:0]         pos_x;
   logic [hhcp_pkg::POS_W-1:0]         pos_y;
   logic signed [hhcp_pkg::HEIGHT_W-1:0] height;
   logic [hhcp_pkg::COLOR_W-1:0]       red;
   logic [hhcp_pkg::COLOR_W-1:0]       green;
   logic [hhcp_pkg::COLOR_W-1:0]       blue;
   logic                               has_color;
   logic [2:0]                         error_code;

   modport source (output valid, pos_x, pos_y, height, red, green, blue, has_color,
                   error_code, input ready);
   modport sink   (input valid, pos_x, pos_y, height, red, green, blue, has_color,
                   error_code, output ready);
endinterface

// File: hw/rtl/hhcp_in_stage.sv
// ----------------------------------------------------------------------------
// Token parser input stage
// Registers each incoming byte transfer ahead of the parser.
// ----------------------------------------------------------------------------
module hhcp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  hhcp_pkg::req_item_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   output hhcp_pkg::req_item_type out_item,
   input  logic                  out_ready
);

   logic                   valid_ff;
   logic                   valid_in;
   hhcp_pkg::req_item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// File: hw/rtl/hhcp_parse.sv
// ----------------------------------------------------------------------------
// Token parser state and result register
// Advances the token state per byte and loads a finished token result.
// ----------------------------------------------------------------------------
`include "height_and_hex_color_token_parser_core_macros.svh"

module hhcp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hhcp_pkg::req_item_type in_item,
   output logic                   in_ready,
   output logic                   rsp_valid,
   output hhcp_pkg::rsp_item_type rsp_item,
   input  logic                   rsp_ready
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SIGN  = 3'd1,
      PH_DIGIT = 3'd2,
      PH_COMMA = 3'd3,
      PH_ZERO  = 3'd4,
      PH_HEX   = 3'd5
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic                            negative_ff, negative_in;
   logic [31:0]                     magnitude_ff, magnitude_in;
   logic                            overflowed_ff, overflowed_in;
   logic [2:0]                      hex_count_ff, hex_count_in;
   logic [23:0]                     color_ff, color_in;
   logic [hhcp_pkg::POS_W-1:0]      lat_x_ff, lat_x_in;
   logic [hhcp_pkg::POS_W-1:0]      lat_y_ff, lat_y_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   hhcp_pkg::rsp_item_type          rsp_item_ff, rsp_item_in;

   logic                            take;
   logic                            emit;
   logic                            emit_color;
   hhcp_pkg::err_type               emit_err;
   logic                            restart;
   logic [hhcp_pkg::CH_W-1:0]       c;
   logic                            c_digit;
   logic [4:0]                      hv;
   logic [35:0]                     prod;
   logic [35:0]                     limit;
   logic                            prod_ovf;
   logic                            good_count;

   assign take      = in_valid && in_ready;
   assign in_ready  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign c          = in_item.ch;
   assign c_digit    = hhcp_pkg::is_digit(c);
   assign hv         = hhcp_pkg::hex_value(c);
   assign good_count = (hex_count_ff == 3'd2) || (hex_count_ff == 3'd4) ||
                       (hex_count_ff == 3'd6);

   // magnitude * 10 + digit
   assign prod     = {1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0} +
                     {32'b0, c[3:0]};
   assign limit    = negative_ff ? 36'h080000000 : 36'h07FFFFFFF;
   assign prod_ovf = prod > limit;

   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      magnitude_in  = magnitude_ff;
      overflowed_in = overflowed_ff;
      hex_count_in  = hex_count_ff;
      color_in      = color_ff;
      lat_x_in      = lat_x_ff;
      lat_y_in      = lat_y_ff;
      emit          = 1'b0;
      emit_color    = 1'b0;
      emit_err      = hhcp_pkg::ERR_NONE;
      restart       = 1'b0;

      unique case (phase_ff)
         PH_SIGN: begin
            if (c_digit) begin
               phase_in = PH_DIGIT;
               if (prod_ovf) begin
                  overflowed_in = 1'b1;
                  magnitude_in  = limit[31:0];
               end else begin
                  magnitude_in = prod[31:0];
               end
            end else begin
               emit     = 1'b1;
               emit_err = hhcp_pkg::ERR_DIGIT;
               restart  = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (c_digit) begin
               if (prod_ovf) begin
                  overflowed_in = 1'b1;
                  magnitude_in  = limit[31:0];
               end else begin
                  magnitude_in = prod[31:0];
               end
            end else if (c == hhcp_pkg::CH_COMMA) begin
               phase_in = PH_COMMA;
            end else begin
               emit     = 1'b1;
               emit_err = overflowed_ff ? hhcp_pkg::ERR_OVERFLOW : hhcp_pkg::ERR_NONE;
               restart  = 1'b1;
            end
         end
         PH_COMMA: begin
            if (c == hhcp_pkg::CH_ZERO) begin
               phase_in = PH_ZERO;
            end else begin
               emit     = 1'b1;
               emit_err = hhcp_pkg::ERR_ZERO_X;
               restart  = 1'b1;
            end
         end
         PH_ZERO: begin
            if (c == hhcp_pkg::CH_X) begin
               phase_in     = PH_HEX;
               hex_count_in = 3'd0;
               color_in     = 24'd0;
            end else begin
               emit     = 1'b1;
               emit_err = hhcp_pkg::ERR_ZERO_X;
               restart  = 1'b1;
            end
         end
         PH_HEX: begin
            if (hv[4]) begin
               if (hex_count_ff < 3'd6) begin
                  color_in = {color_ff[19:0], hv[3:0]};
               end
               if (hex_count_ff != 3'd7) begin
                  hex_count_in = hex_count_ff + 3'd1;
               end
            end else begin
               emit    = 1'b1;
               restart = 1'b1;
               if (good_count) begin
                  emit_color = 1'b1;
                  emit_err   = overflowed_ff ? hhcp_pkg::ERR_OVERFLOW
                                             : hhcp_pkg::ERR_NONE;
               end else begin
                  emit_err = hhcp_pkg::ERR_HEX_COUNT;
               end
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // same byte may open the next token
      if (restart) begin
         phase_in = PH_IDLE;
         if (c_digit || (c == hhcp_pkg::CH_MINUS)) begin
            negative_in   = !c_digit;
            magnitude_in  = c_digit ? {28'b0, c[3:0]} : 32'd0;
            overflowed_in = 1'b0;
            hex_count_in  = 3'd0;
            color_in      = 24'd0;
            lat_x_in      = hhcp_pkg::pos_reduce(in_item.grid_x);
            lat_y_in      = hhcp_pkg::pos_reduce(in_item.grid_y);
            phase_in      = c_digit ? PH_DIGIT : PH_SIGN;
         end
      end
   end

   always_comb begin
      rsp_item_in.pos_x      = lat_x_ff;
      rsp_item_in.pos_y      = lat_y_ff;
      rsp_item_in.height     = negative_ff ? $signed(32'd0 - magnitude_ff)
                                           : $signed(magnitude_ff);
      rsp_item_in.has_color  = emit_color;
      rsp_item_in.error_code = emit_err;
      if (emit_color) begin
         rsp_item_in.blue  = color_ff[7:0];
         rsp_item_in.green = (hex_count_ff >= 3'd4) ? color_ff[15:8] : 8'd0;
         rsp_item_in.red   = (hex_count_ff >= 3'd6) ? color_ff[23:16] : 8'd0;
      end else begin
         rsp_item_in.blue  = 8'hFF;
         rsp_item_in.green = 8'hFF;
         rsp_item_in.red   = 8'hFF;
      end
   end

   assign rsp_valid_in = (take && emit) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         negative_ff   <= 1'b0;
         magnitude_ff  <= 32'd0;
         overflowed_ff <= 1'b0;
         hex_count_ff  <= 3'd0;
         color_ff      <= 24'd0;
         lat_x_ff      <= '0;
         lat_y_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            phase_ff      <= phase_in;
            negative_ff   <= negative_in;
            magnitude_ff  <= magnitude_in;
            overflowed_ff <= overflowed_in;
            hex_count_ff  <= hex_count_in;
            color_ff      <= color_in;
            lat_x_ff      <= lat_x_in;
            lat_y_ff      <= lat_y_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take && emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   `HHCP_ASSERT(a_rsp_from_transfer, clock, reset, $rose(rsp_valid_ff) |-> $past(take))
   `HHCP_ASSERT(a_color_err, clock, reset, (rsp_valid_ff && rsp_item_ff.has_color) |-> (rsp_item_ff.error_code == hhcp_pkg::ERR_NONE || rsp_item_ff.error_code == hhcp_pkg::ERR_OVERFLOW))
   `HHCP_ASSERT(a_white, clock, reset, (rsp_valid_ff && !rsp_item_ff.has_color) |-> (rsp_item_ff.red == 8'hFF && rsp_item_ff.green == 8'hFF && rsp_item_ff.blue == 8'hFF))
   `HHCP_ASSERT(a_sign_clear, clock, reset, (phase_ff == PH_SIGN) |-> (negative_ff && magnitude_ff == 32'd0 && !overflowed_ff))
   `HHCP_ASSERT_NEXT(a_idle_no_rsp, clock, reset, (take && phase_ff == PH_IDLE && !rsp_valid_ff), !rsp_valid_ff)

endmodule

// File: hw/rtl/height_and_hex_color_token_parser_core.sv
// ----------------------------------------------------------------------------
// Height and hex colour token parser
// Byte-stream parser for signed decimal heights with optional 0x colour.
//
//   channel   dir  payload                                          
//   req_chan  in   ch[8], grid_x[10], grid_y[10]
//   rsp_chan  out  pos_x, pos_y, height[32s], red, green, blue,
//                  has_color, error_code[3]
//
// One byte per cycle sustained while no result is stalled; a finished token passes
// the input register and then the result register around the parser.
// A result appears only on the byte that ends a token.
// Synchronous reset returns the parser to idle with no result pending.
// A stalled result holds the parser; the input register keeps taking bytes
// while it has room.
// ----------------------------------------------------------------------------
module height_and_hex_color_token_parser_core (
   input logic        clock,
   input logic        reset,
   hhcp_req_if.sink   req_chan,
   hhcp_rsp_if.source rsp_chan
);

   hhcp_pkg::req_item_type in_item;
   hhcp_pkg::req_item_type stage_item;
   hhcp_pkg::rsp_item_type out_item;
   logic                   stage_valid;
   logic                   stage_ready;

   assign in_item.ch     = req_chan.ch;
   assign in_item.grid_x = req_chan.grid_x;
   assign in_item.grid_y = req_chan.grid_y;

   hhcp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_item   (in_item),
      .in_ready  (req_chan.ready),
      .out_valid (stage_valid),
      .out_item  (stage_item),
      .out_ready (stage_ready)
   );

   hhcp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_item   (stage_item),
      .in_ready  (stage_ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_item  (out_item),
      .rsp_ready (rsp_chan.ready)
   );

   assign rsp_chan.pos_x      = out_item.pos_x;
   assign rsp_chan.pos_y      = out_item.pos_y;
   assign rsp_chan.height     = out_item.height;
   assign rsp_chan.red        = out_item.red;
   assign rsp_chan.green      = out_item.green;
   assign rsp_chan.blue       = out_item.blue;
   assign rsp_chan.has_color  = out_item.has_color;
   assign rsp_chan.error_code = out_item.error_code;

endmodule

// File: tb/sv/height_and_hex_color_token_parser_core_tb.sv
// ----------------------------------------------------------------------------
// Token parser testbench
// Streams text through the parser over valid/ready, predicts every finished
// token in a scoreboard and checks each result transfer field by field.
// Directed cases first, then random well-formed and broken tokens with noise,
// random idle and stall bursts, a long result hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module height_and_hex_color_token_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 400;
   localparam int CALM_ITEMS   = 80;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;

   class token_parse_tracker;
      typedef enum logic [2:0] {
         TOK_IDLE, TOK_SIGN, TOK_DIGITS, TOK_COMMA, TOK_ZERO, TOK_HEX
      } tok_phase_type;

      tok_phase_type              phase;
      logic                       negative;
      logic                       overflowed;
      logic [31:0]                magnitude;
      logic [2:0]                 hex_count;
      logic [23:0]                color_accum;
      logic [hhcp_pkg::POS_W-1:0] lat_x;
      logic [hhcp_pkg::POS_W-1:0] lat_y;
      hhcp_pkg::rsp_item_type     tokens_due[$];
      int unsigned                failures;

      function new();
         phase       = TOK_IDLE;
         negative    = 1'b0;
         overflowed  = 1'b0;
         magnitude   = '0;
         hex_count   = '0;
         color_accum = '0;
         lat_x       = '0;
         lat_y       = '0;
         failures    = 0;
      endfunction

      function bit is_dec(logic [hhcp_pkg::CH_W-1:0] c);
         return (c >= hhcp_pkg::CH_ZERO) && (c <= hhcp_pkg::CH_NINE);
      endfunction

      function int hex_nibble(logic [hhcp_pkg::CH_W-1:0] c);
         if (is_dec(c)) begin
            return int'(c - hhcp_pkg::CH_ZERO);
         end
         if ((c >= hhcp_pkg::CH_LC_A) && (c <= hhcp_pkg::CH_LC_F)) begin
            return int'(c - hhcp_pkg::CH_LC_A) + 10;
         end
         if ((c >= hhcp_pkg::CH_UC_A) && (c <= hhcp_pkg::CH_UC_F)) begin
            return int'(c - hhcp_pkg::CH_UC_A) + 10;
         end
         return -1;
      endfunction

      // Saturates at the int32 limit for the current sign
      function void add_digit(logic [hhcp_pkg::CH_W-1:0] c);
         logic [63:0] lim;
         logic [63:0] v;
         lim = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
         v = {32'd0, magnitude} * 64'd10 + {56'd0, c - hhcp_pkg::CH_ZERO};
         if (v > lim) begin
            overflowed = 1'b1;
            magnitude  = lim[31:0];
         end else begin
            magnitude = v[31:0];
         end
      endfunction

      function void start_token(hhcp_pkg::req_item_type it);
         if ((it.ch == hhcp_pkg::CH_MINUS) || is_dec(it.ch)) begin
            negative    = (it.ch == hhcp_pkg::CH_MINUS);
            magnitude   = '0;
            overflowed  = 1'b0;
            hex_count   = '0;
            color_accum = '0;
            lat_x       = it.grid_x;
            lat_y       = it.grid_y;
            if (it.ch == hhcp_pkg::CH_MINUS) begin
               phase = TOK_SIGN;
            end else begin
               phase = TOK_DIGITS;
               add_digit(it.ch);
            end
         end else begin
            phase = TOK_IDLE;
         end
      endfunction

      function void finish_token(hhcp_pkg::err_type err, bit colored);
         hhcp_pkg::rsp_item_type t;
         t.pos_x  = hhcp_pkg::POS_W'(lat_x % hhcp_pkg::GRID_SIZE);
         t.pos_y  = hhcp_pkg::POS_W'(lat_y % hhcp_pkg::GRID_SIZE);
         t.height = negative ? -magnitude : magnitude;
         t.red    = 8'hFF;
         t.green  = 8'hFF;
         t.blue   = 8'hFF;
         if (colored) begin
            t.red   = 8'h00;
            t.green = 8'h00;
            t.blue  = color_accum[7:0];
            if (hex_count >= 3'd4) begin
               t.green = color_accum[15:8];
            end
            if (hex_count >= 3'd6) begin
               t.red = color_accum[23:16];
            end
         end
         t.has_color  = colored;
         t.error_code = err;
         tokens_due.push_back(t);
      endfunction

      // One accepted input transfer
      function void note_byte(hhcp_pkg::req_item_type it);
         int nib;
         case (phase)
            TOK_SIGN: begin
               if (is_dec(it.ch)) begin
                  add_digit(it.ch);
                  phase = TOK_DIGITS;
                  return;
               end
               finish_token(hhcp_pkg::ERR_DIGIT, 1'b0);
            end
            TOK_DIGITS: begin
               if (is_dec(it.ch)) begin
                  add_digit(it.ch);
                  return;
               end
               if (it.ch == hhcp_pkg::CH_COMMA) begin
                  phase = TOK_COMMA;
                  return;
               end
               finish_token(overflowed ? hhcp_pkg::ERR_OVERFLOW : hhcp_pkg::ERR_NONE,
                            1'b0);
            end
            TOK_COMMA: begin
               if (it.ch == hhcp_pkg::CH_ZERO) begin
                  phase = TOK_ZERO;
                  return;
               end
               finish_token(hhcp_pkg::ERR_ZERO_X, 1'b0);
            end
            TOK_ZERO: begin
               if (it.ch == hhcp_pkg::CH_X) begin
                  phase       = TOK_HEX;
                  hex_count   = '0;
                  color_accum = '0;
                  return;
               end
               finish_token(hhcp_pkg::ERR_ZERO_X, 1'b0);
            end
            TOK_HEX: begin
               nib = hex_nibble(it.ch);
               if (nib >= 0) begin
                  if (hex_count < 3'd6) begin
                     color_accum = {color_accum[19:0], 4'(nib)};
                  end
                  if (hex_count < 3'd7) begin
                     hex_count++;
                  end
                  return;
               end
               if (hex_count inside {3'd2, 3'd4, 3'd6}) begin
                  finish_token(overflowed ? hhcp_pkg::ERR_OVERFLOW : hhcp_pkg::ERR_NONE,
                               1'b1);
               end else begin
                  finish_token(hhcp_pkg::ERR_HEX_COUNT, 1'b0);
               end
            end
            default: begin
               start_token(it);
               return;
            end
         endcase
         start_token(it);
      endfunction

      function void compare_field(string name, logic signed [63:0] want_v,
                                  logic signed [63:0] got_v);
         if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            failures++;
         end
      endfunction

      // One accepted result transfer
      function void check_token(hhcp_pkg::rsp_item_type got);
         hhcp_pkg::rsp_item_type want;
         if (tokens_due.size() == 0) begin
            $error("result transfer with no token pending: height %0d", got.height);
            failures++;
            return;
         end
         want = tokens_due.pop_front();
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("height", want.height, got.height);
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("has_color", want.has_color, got.has_color);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic hold_rsp;
   logic rsp_idling;
   int   stall_left = 0;
   int unsigned quiet_cycles = 0;

   token_parse_tracker tracker;

   hhcp_req_if req_chan();
   hhcp_rsp_if rsp_chan();

   height_and_hex_color_token_parser_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   task automatic send_byte(input logic [hhcp_pkg::CH_W-1:0] c,
                            input logic [hhcp_pkg::POS_W-1:0] gx,
                            input logic [hhcp_pkg::POS_W-1:0] gy, input bit gaps);
      hhcp_pkg::req_item_type it;
      it.ch     = c;
      it.grid_x = gx;
      it.grid_y = gy;
      if (gaps && ($urandom_range(0, 5) == 0)) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.ch     <= c;
      req_chan.grid_x <= gx;
      req_chan.grid_y <= gy;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_byte(it);
   endtask

   // Random token, well formed with random content most of the time; weight is
   // the number of bytes that count towards the stimulus total
   task automatic make_token(ref logic [hhcp_pkg::CH_W-1:0] text[$], output int weight);
      string near_limit[5] = '{"2147483647", "2147483648", "2147483649",
                               "4294967296", "99999999999"};
      string hex_chars = "0123456789abcdefABCDEF";
      string enders    = " ;\n\t-|";
      int    good_counts[3] = '{2, 4, 6};
      int    bad_counts[6]  = '{0, 1, 3, 5, 7, 8};
      int    sel;
      int    mode;
      int    n;
      int    keep;
      string s;
      text.delete();
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
         weight = 0;
         return;
      end
      if ($urandom_range(0, 2) == 0) begin
         text.push_back(hhcp_pkg::CH_MINUS);
      end
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         s = near_limit[$urandom_range(0, 4)];
         for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      end else begin
         n = (mode == 2) ? $urandom_range(9, 12) : $urandom_range(1, 5);
         repeat (n) text.push_back(8'(hhcp_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1) == 1) begin
         text.push_back(hhcp_pkg::CH_COMMA);
         text.push_back(hhcp_pkg::CH_ZERO);
         text.push_back(hhcp_pkg::CH_X);
         n = $urandom_range(0, 9);
         n = (n < 6) ? good_counts[n % 3] : bad_counts[$urandom_range(0, 5)];
         repeat (n) text.push_back(hex_chars[$urandom_range(0, 21)]);
      end
      if (sel < 25) begin
         // broken: cut short and end on an arbitrary byte
         keep = $urandom_range(1, text.size());
         while (text.size() > keep) void'(text.pop_back());
         text.push_back(8'($urandom_range(0, 255)));
      end else begin
         text.push_back(enders[$urandom_range(0, enders.len() - 1)]);
      end
      weight = text.size();
   endtask

   // Result side: check, then decide ready for the next edge
   always @(posedge clock) begin
      hhcp_pkg::rsp_item_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.pos_x      = rsp_chan.pos_x;
         got.pos_y      = rsp_chan.pos_y;
         got.height     = rsp_chan.height;
         got.red        = rsp_chan.red;
         got.green      = rsp_chan.green;
         got.blue       = rsp_chan.blue;
         got.has_color  = rsp_chan.has_color;
         got.error_code = hhcp_pkg::err_type'(rsp_chan.error_code);
         tracker.check_token(got);
      end
      if ((stall_left == 0) && rsp_idling && ($urandom_range(0, 5) == 0)) begin
         stall_left = $urandom_range(1, 14);
      end
      if (reset || hold_rsp || (stall_left != 0)) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
      if (stall_left != 0) begin
         stall_left--;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      string                     directed;
      logic [hhcp_pkg::CH_W-1:0] text[$];
      int                        weight;
      int                        sent;
      int                        tok_no;
      bit                        gaps;
      tracker = new();
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.ch     <= '0;
      req_chan.grid_x <= '0;
      req_chan.grid_y <= '0;
      hold_rsp        <= 1'b0;
      rsp_idling      <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // minus alone, two-digit colour, uppercase X, comma without zero
      directed = "-x9,0xAf;-1,0X3,1 ";
      for (int i = 0; i < directed.len(); i++) begin
         send_byte(directed[i], (i % 2) ? 10'h3FF : 10'h000,
                   (i % 3 == 0) ? 10'h3FF : 10'h000, 1'b1);
      end
      send_byte(8'hFF, 10'h3FF, 10'h000, 1'b1);
      send_byte(8'h00, 10'h000, 10'h3FF, 1'b1);

      sent   = 0;
      tok_no = 0;
      while (sent < RANDOM_ITEMS) begin
         make_token(text, weight);
         gaps = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         rsp_idling <= gaps;
         if (tok_no == 12) begin
            // long result hold-off, sender keeps offering bytes
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (LONG_HOLD) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         if (tok_no == 60) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (tracker.tokens_due.size() != 0);
         end
         foreach (text[i]) begin
            send_byte(text[i], 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)), gaps);
         end
         sent += weight;
         tok_no++;
      end
      send_byte(8'h20, 10'h000, 10'h000, 1'b0);
      req_chan.valid <= 1'b0;

      while (tracker.tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if ((tracker.failures == 0) && (tracker.tokens_due.size() == 0)) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/hhcp_pkg.sv
hw/rtl/hhcp_if.sv
hw/rtl/hhcp_in_stage.sv
hw/rtl/hhcp_parse.sv
hw/rtl/height_and_hex_color_token_parser_core.sv
tb/sv/height_and_hex_color_token_parser_core_tb.sv
